/* rtl/lxwd_pkg.sv */
package lxwd_pkg;

  localparam int HistDepth = 16;
  localparam int SampleW   = 16;
  localparam int CfgW      = 5;
  localparam int CfgIdxW   = 2;
  localparam int OutDataW  = 8;

  localparam logic [CfgW-1:0] ExtremumWindowRst   = CfgW'(3);
  localparam logic [CfgW-1:0] DecreasingLengthRst = CfgW'(3);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef sample_t hist_t [HistDepth];

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXTREMUM_WINDOW   = 2'd0,
    CFG_DECREASING_LENGTH = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic is_decreasing;
    logic prev_is_maximum;
    logic prev_is_minimum;
  } flags_t;

endpackage

/* rtl/lxwd_history.sv */
module lxwd_history (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_en_i,
  input  lxwd_pkg::sample_t  sample_i,
  output lxwd_pkg::hist_t    hist_o
);

  lxwd_pkg::hist_t hist_q;

  // Newest entry at index 0; shift on every accepted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lxwd_pkg::HistDepth; i++) begin
        hist_q[i] <= '0;
      end
    end else if (shift_en_i) begin
      hist_q[0] <= sample_i;
      for (int i = 1; i < lxwd_pkg::HistDepth; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  assign hist_o = hist_q;

endmodule

/* rtl/lxwd_compare.sv */
module lxwd_compare (
  input  lxwd_pkg::sample_t         sample_i,
  input  lxwd_pkg::hist_t           hist_i,
  input  logic [lxwd_pkg::CfgW-1:0] ext_win_i,
  input  logic [lxwd_pkg::CfgW-1:0] dec_len_i,
  output lxwd_pkg::flags_t          flags_o
);

  // Entries beyond the depth never take part, so the oversize window
  // saturates by itself without an explicit clamp.
  always_comb begin
    logic is_min;
    logic is_max;
    logic dec;
    is_min = hist_i[0] < sample_i;
    is_max = hist_i[0] > sample_i;
    for (int i = 1; i < lxwd_pkg::HistDepth; i++) begin
      if (i < int'(ext_win_i)) begin
        if (hist_i[0] >= hist_i[i]) is_min = 1'b0;
        if (hist_i[0] <= hist_i[i]) is_max = 1'b0;
      end
    end
    dec = 1'b1;
    if ((int'(dec_len_i) > 1) && (sample_i >= hist_i[0])) dec = 1'b0;
    for (int i = 1; i < lxwd_pkg::HistDepth - 1; i++) begin
      if ((i + 1 < int'(dec_len_i)) && (hist_i[i-1] >= hist_i[i])) dec = 1'b0;
    end
    flags_o.prev_is_minimum = is_min;
    flags_o.prev_is_maximum = is_max;
    flags_o.is_decreasing   = dec;
  end

endmodule

/* rtl/local_extremum_window_detector_core.sv */
// The result of an accepted input transaction is on the master side in the next cycle.
// One sample per cycle unless the sink stalls; the output register refills as it drains.
// The flags come from a single level of parallel signed compares against the history.
// Reset (rst_ni low, asynchronous): history cleared to zero, both length registers set to 3,
// output register emptied.
module local_extremum_window_detector_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [lxwd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lxwd_pkg::CfgW-1:0]      cfg_wdata_i,
  // sample stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [lxwd_pkg::SampleW-1:0]   s_axis_tdata_i,   // [15:0] sample_in
  // flag stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] prev_is_minimum, [1] prev_is_maximum, [2] is_decreasing, [7:3] zero
  output logic [lxwd_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  logic                      s_fire;
  lxwd_pkg::sample_t         sample;
  lxwd_pkg::hist_t           hist;
  lxwd_pkg::flags_t          flags;
  logic [lxwd_pkg::CfgW-1:0] ext_win_q;
  logic [lxwd_pkg::CfgW-1:0] dec_len_q;
  logic                      out_valid_q;
  logic                      out_valid_d;
  lxwd_pkg::flags_t          out_flags_q;
  lxwd_pkg::flags_t          out_flags_d;

  // Take a new transaction whenever the output register is empty or being drained.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign sample          = lxwd_pkg::sample_t'(s_axis_tdata_i);

  // Configuration registers; writes to unused indexes drop silently.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_win_q <= lxwd_pkg::ExtremumWindowRst;
      dec_len_q <= lxwd_pkg::DecreasingLengthRst;
    end else if (cfg_we_i) begin
      case (lxwd_pkg::cfg_idx_e'(cfg_idx_i))
        lxwd_pkg::CFG_EXTREMUM_WINDOW:   ext_win_q <= cfg_wdata_i;
        lxwd_pkg::CFG_DECREASING_LENGTH: dec_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // History advances on the same edge that captures the flags, so the
  // compare always sees the history from before the current sample.
  lxwd_history u_history (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (s_fire),
    .sample_i   (sample),
    .hist_o     (hist)
  );

  lxwd_compare u_compare (
    .sample_i  (sample),
    .hist_i    (hist),
    .ext_win_i (ext_win_q),
    .dec_len_i (dec_len_q),
    .flags_o   (flags)
  );

  // Output register: load on accept, empty once the sink takes the transaction.
  always_comb begin
    out_valid_d = out_valid_q;
    out_flags_d = out_flags_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (s_fire) begin
      out_valid_d = 1'b1;
      out_flags_d = flags;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_flags_q <= out_flags_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(lxwd_pkg::OutDataW - 3){1'b0}}, out_flags_q};

  // An accepted sample always leaves a result behind it.
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> m_axis_tvalid_o)
    else $error("accepted sample produced no result");

  // The newest history entry is the sample just accepted.
  a_hist_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> hist[0] == $past(sample))
    else $error("history head does not hold the accepted sample");

  // The history moves one place per accepted sample.
  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> hist[1] == $past(hist[0]))
    else $error("history did not shift by one entry");

  // A strict minimum and a strict maximum exclude each other.
  a_min_max_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("minimum and maximum flagged together");

  // A decreasing length of zero or one is met trivially.
  a_short_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (dec_len_q <= lxwd_pkg::CfgW'(1))) |=> m_axis_tdata_o[2])
    else $error("short decreasing length did not flag");

endmodule
